@@ hdl/ffha_pkg.sv @@
// Shared types and codes for the first-fit heap allocator.
// No dependencies; imported by ffha_page_round and first_fit_heap_allocator.
`default_nettype none
package ffha_pkg;
    // width of request sizes and growth amounts in bytes
    localparam int DW = 18;
    localparam int GRAIN = 16;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NULL = 2'd1;
    localparam logic [1:0] ST_OVFL = 2'd2;

    typedef logic [DW-1:0] amt_t;
endpackage
`default_nettype wire

@@ hdl/first_fit_heap_allocator.sv @@
// First-fit heap allocator: block table memory, request sequencer, page rounding.
// Depends on ffha_pkg and ffha_page_round.
//
// The block keeps the arena as an address-ordered table of blocks in one
// single-port-write memory and serves one request word at a time. An allocate
// walks the table from entry zero, with a read step and a check step per block
// visited; a split then moves every later entry up one slot, reading and then
// writing each entry. When nothing fits, the growth amount is rounded to a page
// by a reciprocal multiply and one correction (started with the request and
// mostly hidden behind the scan) and up to three growth attempts follow; an
// overflow restores the table and reports status 2. A free walks the table the
// same way and then merges with its neighbors, moving later entries down one
// slot per merge. The memory read port is the limit throughout. in_stall
// stays high until the result word is in the output register; a finished
// result waits there while the next request is taken. The user must write
// heap_base through cfg_wr_en / cfg_wr_data only while the block is idle;
// the block itself does not enforce this.
`default_nettype none
module first_fit_heap_allocator #(
    parameter int ARENA_BYTES  = 65536,
    parameter int EXPAND_BYTES = 4096,
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wr_en,
    input  wire  [47:0] cfg_wr_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         req_type,
    input  wire  [16:0] req_size,
    input  wire  [47:0] free_address,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [47:0] result_address,
    output logic [1:0]  status
);
    import ffha_pkg::*;

    localparam int MAX_BLOCKS = (ARENA_BYTES + EXPAND_BYTES) / (HEADER_BYTES + 16) + 2;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int OW = $clog2(ARENA_BYTES + 1);
    localparam int EW = 2 * OW + 1;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_ASCAN_RD  = 5'd1;
    localparam logic [4:0] S_ASCAN_CHK = 5'd2;
    localparam logic [4:0] S_ADIV      = 5'd3;
    localparam logic [4:0] S_GROW      = 5'd4;
    localparam logic [4:0] S_REST      = 5'd5;
    localparam logic [4:0] S_TAKE      = 5'd6;
    localparam logic [4:0] S_UP_RD     = 5'd7;
    localparam logic [4:0] S_UP_WR     = 5'd8;
    localparam logic [4:0] S_TAKE_REST = 5'd9;
    localparam logic [4:0] S_TAKE_FIN  = 5'd10;
    localparam logic [4:0] S_FSCAN_RD  = 5'd11;
    localparam logic [4:0] S_FSCAN_CHK = 5'd12;
    localparam logic [4:0] S_NX_RD     = 5'd13;
    localparam logic [4:0] S_NX_CHK    = 5'd14;
    localparam logic [4:0] S_DN_RD     = 5'd15;
    localparam logic [4:0] S_DN_WR     = 5'd16;
    localparam logic [4:0] S_PV_RD     = 5'd17;
    localparam logic [4:0] S_PV_CHK    = 5'd18;
    localparam logic [4:0] S_DONE      = 5'd19;

    // entry packing: {free, size, offset}
    localparam logic [EW-1:0] RESET_ENTRY =
        {1'b1, OW'(EXPAND_BYTES - HEADER_BYTES), OW'(0)};

    // block table
    logic [EW-1:0] mem [MAX_BLOCKS];
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata;
    logic [EW-1:0] rd_raw_reg;
    logic          rd_dflt_reg;
    logic          v0_reg;
    logic [EW-1:0] rdata;
    logic [OW-1:0] rd_off, rd_size;
    logic          rd_free;

    logic [4:0]    state_reg, state_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW:0]   j_reg, j_next;
    logic [IW-1:0] last_reg, last_next;
    logic [OW-1:0] mapped_reg, mapped_next;
    logic [47:0]   base_reg;
    amt_t          sz_reg, sz_next;
    logic [47:0]   foff_reg, foff_next;
    logic [OW-1:0] cur_off_reg, cur_off_next;
    logic [OW-1:0] cur_size_reg, cur_size_next;
    logic          cur_free_reg, cur_free_next;
    logic [IW-1:0] sv_last_reg, sv_last_next;
    logic [OW-1:0] sv_mapped_reg, sv_mapped_next;
    logic [EW-1:0] sv_entry_reg, sv_entry_next;
    logic [1:0]    tries_reg, tries_next;
    logic          drop_cur_reg, drop_cur_next;
    logic [47:0]   res_addr_reg, res_addr_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic          out_valid_reg, out_valid_next;
    logic [47:0]   out_addr_reg;
    logic [1:0]    out_st_reg;
    logic          out_load;

    // growth amount
    logic          div_start, div_busy;
    amt_t          div_x, amt;
    amt_t          sz_c;
    logic [31:0]   grow_end;
    logic [OW-1:0] grown_size;
    logic [47:0]   take_addr;

    assign rdata   = rd_dflt_reg ? RESET_ENTRY : rd_raw_reg;
    assign rd_off  = rdata[OW-1:0];
    assign rd_size = rdata[2*OW-1:OW];
    assign rd_free = rdata[2*OW];

    assign sz_c  = (DW'(req_size) + DW'(GRAIN - 1)) & ~DW'(GRAIN - 1);
    assign div_x = (sz_c > DW'(EXPAND_BYTES))
                 ? ((sz_c + DW'(HEADER_BYTES + GRAIN - 1)) & ~DW'(GRAIN - 1))
                 : DW'(EXPAND_BYTES);

    ffha_page_round #(.PAGE_BYTES(PAGE_BYTES)) u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .x     (div_x),
        .busy  (div_busy),
        .amt   (amt)
    );

    assign grow_end   = 32'(mapped_reg) + 32'(amt);
    assign grown_size = cur_free_reg ? OW'(32'(cur_size_reg) + 32'(amt))
                                     : OW'(32'(amt) - 32'(HEADER_BYTES));
    assign take_addr  = base_reg + 48'(cur_off_reg) + 48'(HEADER_BYTES);

    assign in_stall = (state_reg != S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        last_next      = last_reg;
        mapped_next    = mapped_reg;
        sz_next        = sz_reg;
        foff_next      = foff_reg;
        cur_off_next   = cur_off_reg;
        cur_size_next  = cur_size_reg;
        cur_free_next  = cur_free_reg;
        sv_last_next   = sv_last_reg;
        sv_mapped_next = sv_mapped_reg;
        sv_entry_next  = sv_entry_reg;
        tries_next     = tries_reg;
        drop_cur_next  = drop_cur_reg;
        res_addr_next  = res_addr_reg;
        res_st_next    = res_st_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_addr_next = '0;
                    res_st_next   = ST_DONE;
                    i_next        = '0;
                    if (req_type == REQ_ALLOC)
                    begin
                        sz_next = sz_c;
                        if (req_size == '0)
                        begin
                            res_st_next = ST_NULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_ASCAN_RD;
                        end
                    end
                    else if (free_address == '0)
                        state_next = S_DONE;
                    else
                    begin
                        foff_next  = free_address - base_reg - 48'(HEADER_BYTES);
                        state_next = S_FSCAN_RD;
                    end
                end
            end

            S_ASCAN_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = i_reg;
                state_next = S_ASCAN_CHK;
            end

            S_ASCAN_CHK:
            begin
                cur_off_next  = rd_off;
                cur_size_next = rd_size;
                cur_free_next = rd_free;
                idx_next      = i_reg;
                if (rd_free && 32'(rd_size) >= 32'(sz_reg))
                    state_next = S_TAKE;
                else if (i_reg == last_reg)
                begin
                    sv_last_next   = last_reg;
                    sv_mapped_next = mapped_reg;
                    sv_entry_next  = rdata;
                    tries_next     = '0;
                    state_next     = S_ADIV;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_ASCAN_RD;
                end
            end

            S_ADIV:
            begin
                if (!div_busy)
                    state_next = S_GROW;
            end

            S_GROW:
            begin
                if (grow_end > 32'(ARENA_BYTES) ||
                    (!cur_free_reg && 32'(last_reg) + 32'd1 >= 32'(MAX_BLOCKS)))
                    state_next = S_REST;
                else
                begin
                    mem_we      = 1'b1;
                    mapped_next = OW'(grow_end);
                    if (cur_free_reg)
                    begin
                        mem_waddr = last_reg;
                        mem_wdata = {1'b1, grown_size, cur_off_reg};
                    end
                    else
                    begin
                        // append a fresh free block at the old end
                        mem_waddr    = last_reg + IW'(1);
                        mem_wdata    = {1'b1, grown_size, mapped_reg};
                        last_next    = last_reg + IW'(1);
                        cur_off_next = mapped_reg;
                    end
                    cur_size_next = grown_size;
                    cur_free_next = 1'b1;
                    idx_next      = cur_free_reg ? last_reg : last_reg + IW'(1);
                    tries_next    = tries_reg + 2'd1;
                    if (32'(grown_size) >= 32'(sz_reg))
                        state_next = S_TAKE;
                    else if (tries_reg == 2'd2)
                        state_next = S_REST;
                end
            end

            S_REST:
            begin
                // undo any growth done for this request
                mem_we        = 1'b1;
                mem_waddr     = sv_last_reg;
                mem_wdata     = sv_entry_reg;
                last_next     = sv_last_reg;
                mapped_next   = sv_mapped_reg;
                res_addr_next = '0;
                res_st_next   = ST_OVFL;
                state_next    = S_DONE;
            end

            S_TAKE:
            begin
                if (32'(cur_size_reg) >= 32'(sz_reg) + 32'(HEADER_BYTES + GRAIN) &&
                    32'(last_reg) + 32'd1 < 32'(MAX_BLOCKS))
                begin
                    j_next = (IW+1)'(last_reg);
                    if ((IW+1)'(last_reg) >= (IW+1)'(idx_reg) + (IW+1)'(1))
                        state_next = S_UP_RD;
                    else
                        state_next = S_TAKE_REST;
                end
                else
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = idx_reg;
                    mem_wdata     = {1'b0, cur_size_reg, cur_off_reg};
                    res_addr_next = take_addr;
                    state_next    = S_DONE;
                end
            end

            S_UP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = j_reg[IW-1:0];
                state_next = S_UP_WR;
            end

            S_UP_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = IW'(j_reg + (IW+1)'(1));
                mem_wdata = rdata;
                if (j_reg == (IW+1)'(idx_reg) + (IW+1)'(1))
                    state_next = S_TAKE_REST;
                else
                begin
                    j_next     = j_reg - (IW+1)'(1);
                    state_next = S_UP_RD;
                end
            end

            S_TAKE_REST:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg + IW'(1);
                mem_wdata  = {1'b1,
                              OW'(32'(cur_size_reg) - 32'(sz_reg) - 32'(HEADER_BYTES)),
                              OW'(32'(cur_off_reg) + 32'(HEADER_BYTES) + 32'(sz_reg))};
                state_next = S_TAKE_FIN;
            end

            S_TAKE_FIN:
            begin
                mem_we        = 1'b1;
                mem_waddr     = idx_reg;
                mem_wdata     = {1'b0, OW'(sz_reg), cur_off_reg};
                last_next     = last_reg + IW'(1);
                res_addr_next = take_addr;
                state_next    = S_DONE;
            end

            S_FSCAN_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = i_reg;
                state_next = S_FSCAN_CHK;
            end

            S_FSCAN_CHK:
            begin
                if (!rd_free && 48'(rd_off) == foff_reg)
                begin
                    cur_off_next  = rd_off;
                    cur_size_next = rd_size;
                    idx_next      = i_reg;
                    state_next    = (i_reg != last_reg) ? S_NX_RD : S_PV_RD;
                end
                else if (i_reg == last_reg)
                    state_next = S_DONE;    // unknown address or double free
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_FSCAN_RD;
                end
            end

            S_NX_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg + IW'(1);
                state_next = S_NX_CHK;
            end

            S_NX_CHK:
            begin
                state_next = S_PV_RD;
                if (rd_free)
                begin
                    cur_size_next = OW'(32'(cur_size_reg) + 32'(rd_size) + 32'(HEADER_BYTES));
                    j_next        = (IW+1)'(idx_reg) + (IW+1)'(2);
                    drop_cur_next = 1'b0;
                    if ((IW+1)'(idx_reg) + (IW+1)'(2) <= (IW+1)'(last_reg))
                        state_next = S_DN_RD;
                    else
                        last_next = last_reg - IW'(1);
                end
            end

            S_DN_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = j_reg[IW-1:0];
                state_next = S_DN_WR;
            end

            S_DN_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = IW'(j_reg - (IW+1)'(1));
                mem_wdata = rdata;
                if (j_reg == (IW+1)'(last_reg))
                begin
                    last_next  = last_reg - IW'(1);
                    state_next = drop_cur_reg ? S_DONE : S_PV_RD;
                end
                else
                begin
                    j_next     = j_reg + (IW+1)'(1);
                    state_next = S_DN_RD;
                end
            end

            S_PV_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = idx_reg;
                    mem_wdata  = {1'b1, cur_size_reg, cur_off_reg};
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg - IW'(1);
                    state_next = S_PV_CHK;
                end
            end

            S_PV_CHK:
            begin
                mem_we     = 1'b1;
                state_next = S_DONE;
                if (rd_free)
                begin
                    // fold this block into its free predecessor, then drop it
                    mem_waddr = idx_reg - IW'(1);
                    mem_wdata = {1'b1,
                                 OW'(32'(rd_size) + 32'(cur_size_reg) + 32'(HEADER_BYTES)),
                                 rd_off};
                    j_next        = (IW+1)'(idx_reg) + (IW+1)'(1);
                    drop_cur_next = 1'b1;
                    if ((IW+1)'(idx_reg) + (IW+1)'(1) <= (IW+1)'(last_reg))
                        state_next = S_DN_RD;
                    else
                        last_next = last_reg - IW'(1);
                end
                else
                begin
                    mem_waddr = idx_reg;
                    mem_wdata = {1'b1, cur_size_reg, cur_off_reg};
                end
            end

            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_reg      <= '0;
            mapped_reg    <= OW'(EXPAND_BYTES);
            base_reg      <= '0;
            v0_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            mapped_reg    <= mapped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                base_reg <= cfg_wr_data;
            if (mem_we && mem_waddr == '0)
                v0_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        idx_reg       <= idx_next;
        j_reg         <= j_next;
        sz_reg        <= sz_next;
        foff_reg      <= foff_next;
        cur_off_reg   <= cur_off_next;
        cur_size_reg  <= cur_size_next;
        cur_free_reg  <= cur_free_next;
        sv_last_reg   <= sv_last_next;
        sv_mapped_reg <= sv_mapped_next;
        sv_entry_reg  <= sv_entry_next;
        tries_reg     <= tries_next;
        drop_cur_reg  <= drop_cur_next;
        res_addr_reg  <= res_addr_next;
        res_st_reg    <= res_st_next;
        if (out_load)
        begin
            out_addr_reg <= res_addr_reg;
            out_st_reg   <= res_st_reg;
        end
    end

    // block table memory; entry zero reads as the initial block until written
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
        begin
            rd_raw_reg  <= mem[mem_raddr];
            rd_dflt_reg <= (mem_raddr == '0) && !v0_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_st_reg;

    a_mapped_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(mapped_reg) <= 32'(ARENA_BYTES))
        else $error("mapped bytes beyond arena");

    a_last_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(last_reg) < 32'(MAX_BLOCKS))
        else $error("block index beyond table");

    a_null_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OVFL || status == ST_NULL) |-> result_address == '0)
        else $error("failed request carries an address");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status code");
endmodule
`default_nettype wire

@@ hdl/ffha_page_round.sv @@
// Rounds a byte count up to a multiple of PAGE_BYTES by reciprocal multiplication.
// Depends on ffha_pkg.
`default_nettype none
module ffha_page_round #(
    parameter int PAGE_BYTES = 4096
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    input  ffha_pkg::amt_t x,
    output logic           busy,
    output ffha_pkg::amt_t amt
);
    import ffha_pkg::*;

    // n = x + PAGE - 1; floor(n / PAGE) is estimated as (n * RECIP) >> DW,
    // which is at most one low because n < 2^DW; the last step adds it back
    localparam logic [DW-1:0] RECIP = DW'((2 ** DW) / PAGE_BYTES);
    localparam logic [DW-1:0] PAGE  = DW'(PAGE_BYTES);

    localparam logic [1:0] PH_EST = 2'd0;
    localparam logic [1:0] PH_MUL = 2'd1;
    localparam logic [1:0] PH_FIX = 2'd2;

    logic            busy_reg, busy_next;
    logic [1:0]      ph_reg, ph_next;
    logic [DW-1:0]   num_reg, num_next;
    logic [DW-1:0]   q_reg, q_next;
    logic [DW-1:0]   p_reg, p_next;
    amt_t            amt_reg, amt_next;
    logic [2*DW-1:0] est;
    logic [2*DW-1:0] prod;

    assign est  = (2*DW)'(num_reg) * (2*DW)'(RECIP);
    assign prod = (2*DW)'(q_reg) * (2*DW)'(PAGE);

    always_comb
    begin
        busy_next = busy_reg;
        ph_next   = ph_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        p_next    = p_reg;
        amt_next  = amt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            ph_next   = PH_EST;
            num_next  = x + DW'(PAGE_BYTES - 1);
        end
        else if (busy_reg)
        begin
            case (ph_reg)
                PH_EST:
                begin
                    q_next  = est[2*DW-1:DW];
                    ph_next = PH_MUL;
                end
                PH_MUL:
                begin
                    p_next  = prod[DW-1:0];
                    ph_next = PH_FIX;
                end
                PH_FIX:
                begin
                    // estimate one page short when the remainder is a full page
                    amt_next  = (num_reg - p_reg >= PAGE) ? p_reg + PAGE : p_reg;
                    busy_next = 1'b0;
                    ph_next   = PH_EST;
                end
                default:
                begin
                    busy_next = 1'b0;
                    ph_next   = PH_EST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg   <= PH_EST;
        end
        else
        begin
            busy_reg <= busy_next;
            ph_reg   <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        q_reg   <= q_next;
        p_reg   <= p_next;
        amt_reg <= amt_next;
    end

    assign busy = busy_reg;
    assign amt  = amt_reg;
endmodule
`default_nettype wire
